/* rtl/core/ashp_pkg.sv */
// Shared types and constants for the ASCII signed hex/decimal parser.
`timescale 1ns / 1ps

package ashp_pkg;

  localparam int unsigned RESULT_BITS = 64;
  localparam int unsigned DEC_BASE    = 10;

  // Largest hex magnitude that can still take one more digit (0xFFFFFFFF >> 4)
  localparam logic [31:0] HEX_PRE_MAX = 32'h0FFF_FFFF;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef enum logic [2:0] {
    PH_START,
    PH_MINUS,
    PH_ZERO,
    PH_PREFIX,
    PH_HEX,
    PH_DEC,
    PH_ENDED
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SYNTAX   = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    phase_e phase;
    logic   negative;
    logic   syntax_bad;
    logic   overflowed;
  } flags_t;

  localparam flags_t FLAGS_RESET = '{phase: PH_START, negative: 1'b0,
                                     syntax_bad: 1'b0, overflowed: 1'b0};

endpackage

/* rtl/core/ashp_step.sv */
// Per-character parser step: phase update, digit accumulation, final value.
`timescale 1ns / 1ps

module ashp_step #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  ashp_pkg::flags_t         flags_i,
  input  logic [VALUE_WIDTH-1:0]   acc_i,
  input  logic [VALUE_WIDTH-1:0]   nacc_i,
  input  logic [7:0]               char_code_i,
  input  logic                     last_i,
  output ashp_pkg::flags_t         flags_o,
  output logic [VALUE_WIDTH-1:0]   acc_o,
  output logic [VALUE_WIDTH-1:0]   nacc_o,
  output logic [ashp_pkg::RESULT_BITS-1:0] value_o,
  output logic [1:0]               status_o
);
  import ashp_pkg::*;

  localparam logic [VALUE_WIDTH-1:0] HALF    = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] BASE    = VALUE_WIDTH'(DEC_BASE);
  localparam logic [VALUE_WIDTH-1:0] POS_LIM = HALF - VALUE_WIDTH'(1);
  localparam logic [VALUE_WIDTH-1:0] POS_DIV = POS_LIM / BASE;
  localparam logic [VALUE_WIDTH-1:0] NEG_DIV = HALF / BASE;
  localparam logic [3:0]             POS_MOD = 4'(POS_LIM % BASE);
  localparam logic [3:0]             NEG_MOD = 4'(HALF % BASE);
  localparam logic [VALUE_WIDTH-1:0] HEX_MAX =
    {{(VALUE_WIDTH-32){1'b0}}, HEX_PRE_MAX};

  flags_t                 fl;
  logic                   is_dec;
  logic                   is_hex;
  logic [3:0]             digit;
  logic                   add_dec;
  logic                   add_hex;
  logic [VALUE_WIDTH-1:0] lim_div;
  logic [3:0]             lim_mod;
  logic [VALUE_WIDTH-1:0] sel;

  always_comb begin
    is_dec = (char_code_i inside {[CH_ZERO:CH_NINE]});
    is_hex = is_dec || (char_code_i inside {[CH_LA:CH_LF], [CH_UA:CH_UF]});
    // letters a-f / A-F have low nibble 1..6
    digit  = is_dec ? char_code_i[3:0] : (char_code_i[3:0] + 4'd9);

    fl      = flags_i;
    add_dec = 1'b0;
    add_hex = 1'b0;

    if (flags_i.phase != PH_ENDED) begin
      if (char_code_i == CH_NUL) begin
        if (flags_i.phase inside {PH_START, PH_PREFIX}) fl.syntax_bad = 1'b1;
        fl.phase = PH_ENDED;
      end else begin
        case (flags_i.phase)
          PH_START, PH_MINUS: begin
            if (char_code_i == CH_MINUS && flags_i.phase == PH_START) begin
              fl.negative = 1'b1;
              fl.phase    = PH_MINUS;
            end else if (char_code_i == CH_ZERO) begin
              fl.phase = PH_ZERO;
            end else begin
              fl.phase = PH_DEC;
              if (is_dec) add_dec = 1'b1;
              else        fl.syntax_bad = 1'b1;
            end
          end
          PH_ZERO: begin
            if (char_code_i == CH_X) begin
              fl.phase = PH_PREFIX;
            end else begin
              fl.phase = PH_DEC;
              if (is_dec) add_dec = 1'b1;
              else        fl.syntax_bad = 1'b1;
            end
          end
          PH_PREFIX, PH_HEX: begin
            fl.phase = PH_HEX;
            if (is_hex) add_hex = 1'b1;
            else        fl.syntax_bad = 1'b1;
          end
          default: begin
            if (is_dec) add_dec = 1'b1;
            else        fl.syntax_bad = 1'b1;
          end
        endcase
      end
    end

    // magnitude and its two's complement are kept side by side
    lim_div = flags_i.negative ? NEG_DIV : POS_DIV;
    lim_mod = flags_i.negative ? NEG_MOD : POS_MOD;
    acc_o   = acc_i;
    nacc_o  = nacc_i;
    if (add_dec && !flags_i.overflowed) begin
      if (acc_i > lim_div || (acc_i == lim_div && digit > lim_mod)) begin
        fl.overflowed = 1'b1;
      end else begin
        acc_o  = (acc_i << 3) + (acc_i << 1) + VALUE_WIDTH'(digit);
        nacc_o = (nacc_i << 3) + (nacc_i << 1) - VALUE_WIDTH'(digit);
      end
    end
    if (add_hex && !flags_i.overflowed) begin
      if (acc_i > HEX_MAX) begin
        fl.overflowed = 1'b1;
      end else begin
        acc_o  = {acc_i[VALUE_WIDTH-5:0], digit};
        nacc_o = {nacc_i[VALUE_WIDTH-5:0], 4'b0000} - VALUE_WIDTH'(digit);
      end
    end

    // end of string on the last word
    if (last_i) begin
      if (fl.phase inside {PH_START, PH_PREFIX}) fl.syntax_bad = 1'b1;
      fl.phase = PH_ENDED;
    end
    flags_o = fl;

    sel = fl.negative ? nacc_o : acc_o;
    if (fl.syntax_bad) begin
      value_o  = '1;
      status_o = ST_SYNTAX;
    end else if (fl.overflowed) begin
      value_o  = '1;
      status_o = ST_OVERFLOW;
    end else begin
      value_o  = RESULT_BITS'($signed(sel));
      status_o = ST_OK;
    end
  end

endmodule

/* rtl/core/ascii_signed_hex_dec_parser.sv */
// Top level of the ASCII signed hex/decimal string parser.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one ASCII character per
//   word, with last_i marking the final character of a string. A 0 character
//   terminates the string early; later characters up to last are ignored.
//   Output channel (out_valid_o / out_ready_i) carries one word per string,
//   produced for the input word marked last: value_o (signed 64-bit, -1 on
//   error) and status_o (0 ok, 1 bad syntax or empty, 2 overflow).
// Timing:
//   One character per cycle sustained, except while a last character waits
//   for the output. A word is captured in the input register, is folded into
//   the parser state by one shift-add step, and the result of a last character
//   lands in the output register. The x10 / x16 shift-add sets the cycle time.
// Reset:
//   rst_ni clears both registers' valid flags and the parser state; the
//   first string may start right after reset.
// Back-pressure:
//   Non-last characters never wait for the output. A last character waits in
//   the input register while an earlier result is still held; in_ready_o then
//   drops until out_ready_i takes that result.

module ascii_signed_hex_dec_parser #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_o,
  output logic [1:0]  status_o
);
  import ashp_pkg::*;

  logic                   in_vld_q;
  logic [7:0]             char_q;
  logic                   last_q;
  flags_t                 flags_q, flags_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [VALUE_WIDTH-1:0] nacc_q, nacc_d;
  logic                   out_vld_q;
  logic [63:0]            value_q, value_d;
  logic [1:0]             status_q, status_d;
  logic                   out_free;
  logic                   adv;
  logic                   in_take;

  assign out_free   = !out_vld_q || out_ready_i;
  assign adv        = in_vld_q && (!last_q || out_free);
  assign in_ready_o = !in_vld_q || adv;
  assign in_take    = in_valid_i && in_ready_o;

  ashp_step #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_step (
    .flags_i     (flags_q),
    .acc_i       (acc_q),
    .nacc_i      (nacc_q),
    .char_code_i (char_q),
    .last_i      (last_q),
    .flags_o     (flags_d),
    .acc_o       (acc_d),
    .nacc_o      (nacc_d),
    .value_o     (value_d),
    .status_o    (status_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q <= char_code_i;
      last_q <= last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= FLAGS_RESET;
      acc_q   <= '0;
      nacc_q  <= '0;
    end else if (adv) begin
      if (last_q) begin
        flags_q <= FLAGS_RESET;
        acc_q   <= '0;
        nacc_q  <= '0;
      end else begin
        flags_q <= flags_d;
        acc_q   <= acc_d;
        nacc_q  <= nacc_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && last_q) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_q) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

/* rtl/core/ashp_checker.sv */
// Port-level assertions for the parser, bound to the top level.
`timescale 1ns / 1ps

module ashp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] value_o,
  input logic [1:0]  status_o
);
  import ashp_pkg::*;

  // held result must not move while the receiver stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o) && $stable(status_o))
    else $error("result changed while stalled");

  // any fault reports all ones
  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_SYNTAX || status_o == ST_OVERFLOW) |-> value_o == '1)
    else $error("error status without -1 value");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_SYNTAX || status_o == ST_OVERFLOW)
    else $error("status code out of range");

  // input only stalls behind a held, untaken result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with free output");

  // a result needs two register stages after reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind ascii_signed_hex_dec_parser ashp_checker u_ashp_checker (.*);
